>>> design/lfu_page_replacement_top_assert.svh
// Assertion macros shared by the LFU replacement block.
`ifndef LFU_PAGE_REPLACEMENT_TOP_ASSERT_SVH
`define LFU_PAGE_REPLACEMENT_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
`define LFU_ASSERT_IMPLIES(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("LFU assertion failed");
`define LFU_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("LFU assertion failed");
`else
`define LFU_ASSERT_IMPLIES(label, clk, rstn, ante, cons)
`define LFU_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

>>> design/lfu_pkg.sv
package lfu_pkg;

    localparam int SLOTS        = 16;
    localparam int PAGE_ID_BITS = 16;
    localparam int COUNT_BITS   = 16;
    localparam int CFG_BITS     = 5;
    localparam int IDX_BITS     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int OCC_BITS     = $clog2(SLOTS + 1);
    localparam int CMP_BITS     = (OCC_BITS > CFG_BITS) ? OCC_BITS : CFG_BITS;
    localparam int IN_BITS      = 16;
    localparam int OUT_BITS     = 24;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } lfu_state_t;

    // Search token that walks the row of slot cells.
    typedef struct packed {
        logic                    valid;
        logic [PAGE_ID_BITS-1:0] page;
        logic                    hit;
        logic [IDX_BITS-1:0]     hit_idx;
        logic [OCC_BITS-1:0]     occ;
        logic                    vic_valid;
        logic [COUNT_BITS-1:0]   vic_count;
        logic [PAGE_ID_BITS-1:0] vic_page;
        logic [IDX_BITS-1:0]     vic_idx;
        logic                    free_valid;
        logic [IDX_BITS-1:0]     free_idx;
    } lfu_token_t;

    // Update broadcast to all cells once the search is complete.
    typedef struct packed {
        logic                    hit_inc;
        logic [IDX_BITS-1:0]     hit_idx;
        logic                    evict;
        logic [IDX_BITS-1:0]     vic_idx;
        logic                    install;
        logic [IDX_BITS-1:0]     ins_idx;
        logic [PAGE_ID_BITS-1:0] page;
    } lfu_cmd_t;

endpackage

>>> design/lfu_page_replacement_top.sv
// LFU buffer pool replacement.
// The s_ channel carries one requested page id per transfer (s_tdata).
// The m_ channel returns one result per request: hit, evicted and the
// evicted page id. cfg_wr_en/cfg_wr_data write the pool capacity; write
// it only while no request is in flight.
// A request walks a row of SLOTS slot cells, one cell per cycle, which
// gathers the hit slot, occupancy, least frequently used victim and first
// free slot. A register then holds that outcome; from it the update is
// applied to all cells and the output register loaded in the same cycle.
// Requests are handled one at a time; the next one is taken once the
// update is applied.
// The output register frees the input side: a new request is accepted
// while a result still waits. If the receiver stalls with a result held,
// the next request completes its walk and waits before updating the pool.
// Reset empties the pool, clears all counts and sets the capacity to 16;
// s_tready stays low while reset is held.
module lfu_page_replacement_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [lfu_pkg::IN_BITS-1:0]   s_tdata,   // [15:0] page_id
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [lfu_pkg::OUT_BITS-1:0]  m_tdata,   // [0] hit, [1] evicted,
                                                     // [17:2] evicted_page
    input  logic                          cfg_wr_en,
    input  logic [lfu_pkg::CFG_BITS-1:0]  cfg_wr_data
);

    `include "lfu_page_replacement_top_assert.svh"

    lfu_pkg::lfu_state_t               state_reg, state_next;
    logic [lfu_pkg::CFG_BITS-1:0]      cap_reg;
    lfu_pkg::lfu_token_t               tok [lfu_pkg::SLOTS+1];
    lfu_pkg::lfu_token_t               res_reg, res_next;
    lfu_pkg::lfu_cmd_t                 cmd;
    logic                              m_tvalid_reg, m_tvalid_next;
    logic [lfu_pkg::OUT_BITS-1:0]      m_tdata_reg, m_tdata_next;
    logic [lfu_pkg::CMP_BITS-1:0]      cap_ext, cap_eff, occ_ext;
    logic                              evict, issue;
    logic [lfu_pkg::SLOTS-1:0]         tok_valid_vec;

    always_comb begin
        tok[0]       = '0;
        tok[0].valid = s_tvalid && s_tready;
        tok[0].page  = s_tdata[lfu_pkg::PAGE_ID_BITS-1:0];
    end

    for (genvar i = 0; i < lfu_pkg::SLOTS; i++) begin : g_cell
        lfu_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .cell_idx (lfu_pkg::IDX_BITS'(i)),
            .tok_in   (tok[i]),
            .cmd      (cmd),
            .tok_out  (tok[i+1])
        );
        assign tok_valid_vec[i] = tok[i+1].valid;
    end

    // A capacity of zero acts as one, and values above the slot count clamp.
    always_comb begin
        cap_ext = lfu_pkg::CMP_BITS'(cap_reg);
        occ_ext = lfu_pkg::CMP_BITS'(res_reg.occ);
        if (cap_ext == '0) begin
            cap_eff = lfu_pkg::CMP_BITS'(1);
        end else if (cap_ext > lfu_pkg::CMP_BITS'(lfu_pkg::SLOTS)) begin
            cap_eff = lfu_pkg::CMP_BITS'(lfu_pkg::SLOTS);
        end else begin
            cap_eff = cap_ext;
        end
    end

    assign evict = !res_reg.hit && res_reg.vic_valid && (occ_ext >= cap_eff);

    always_comb begin
        state_next    = state_reg;
        res_next      = res_reg;
        issue         = 1'b0;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        s_tready      = 1'b0;
        cmd           = '0;

        unique case (state_reg)
            lfu_pkg::ST_IDLE: begin
                s_tready = aresetn;
                if (s_tvalid) begin
                    state_next = lfu_pkg::ST_SCAN;
                end
            end
            lfu_pkg::ST_SCAN: begin
                if (tok[lfu_pkg::SLOTS].valid) begin
                    res_next   = tok[lfu_pkg::SLOTS];
                    state_next = lfu_pkg::ST_DONE;
                end
            end
            lfu_pkg::ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    issue         = 1'b1;
                    state_next    = lfu_pkg::ST_IDLE;
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = '0;
                    m_tdata_next[0] = res_reg.hit;
                    m_tdata_next[1] = evict;
                    if (evict) begin
                        m_tdata_next[17:2] = 16'(res_reg.vic_page);
                    end
                    cmd.page    = res_reg.page;
                    cmd.hit_inc = res_reg.hit;
                    cmd.hit_idx = res_reg.hit_idx;
                    cmd.evict   = evict;
                    cmd.vic_idx = res_reg.vic_idx;
                    if (!res_reg.hit) begin
                        cmd.install = evict || res_reg.free_valid;
                        if (evict && !(res_reg.free_valid &&
                                       res_reg.free_idx < res_reg.vic_idx)) begin
                            cmd.ins_idx = res_reg.vic_idx;
                        end else begin
                            cmd.ins_idx = res_reg.free_idx;
                        end
                    end
                end
            end
            default: begin
                state_next = lfu_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= lfu_pkg::ST_IDLE;
            cap_reg      <= lfu_pkg::CFG_BITS'(16);
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_wr_en) begin
                cap_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        res_reg     <= res_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `LFU_ASSERT_NEXT(a_accept_enters_row, aclk, aresetn, s_tvalid && s_tready, tok[1].valid)
    `LFU_ASSERT_IMPLIES(a_one_token, aclk, aresetn, 1'b1, $onehot0(tok_valid_vec))
    `LFU_ASSERT_NEXT(a_issue_gives_result, aclk, aresetn, issue, m_tvalid)
    `LFU_ASSERT_IMPLIES(a_evict_only_on_miss, aclk, aresetn, m_tvalid && m_tdata[1], !m_tdata[0])

endmodule

>>> design/lfu_cell.sv
module lfu_cell (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [lfu_pkg::IDX_BITS-1:0]  cell_idx,
    input  lfu_pkg::lfu_token_t           tok_in,
    input  lfu_pkg::lfu_cmd_t             cmd,
    output lfu_pkg::lfu_token_t           tok_out
);

    logic                               valid_reg, valid_next;
    logic [lfu_pkg::PAGE_ID_BITS-1:0]   page_reg, page_next;
    logic [lfu_pkg::COUNT_BITS-1:0]     count_reg, count_next;
    lfu_pkg::lfu_token_t                tok_reg, tok_next;

    always_comb begin
        tok_next = tok_in;
        if (valid_reg) begin
            if (!tok_in.hit && page_reg == tok_in.page) begin
                tok_next.hit     = 1'b1;
                tok_next.hit_idx = cell_idx;
            end
            tok_next.occ = tok_in.occ + lfu_pkg::OCC_BITS'(1);
            if (!tok_in.vic_valid || count_reg < tok_in.vic_count ||
                (count_reg == tok_in.vic_count && page_reg < tok_in.vic_page)) begin
                tok_next.vic_valid = 1'b1;
                tok_next.vic_count = count_reg;
                tok_next.vic_page  = page_reg;
                tok_next.vic_idx   = cell_idx;
            end
        end else if (!tok_in.free_valid) begin
            tok_next.free_valid = 1'b1;
            tok_next.free_idx   = cell_idx;
        end
    end

    // An install into the victim's slot takes precedence over its eviction.
    always_comb begin
        valid_next = valid_reg;
        page_next  = page_reg;
        count_next = count_reg;
        if (cmd.install && cmd.ins_idx == cell_idx) begin
            valid_next = 1'b1;
            page_next  = cmd.page;
            count_next = lfu_pkg::COUNT_BITS'(1);
        end else if (cmd.evict && cmd.vic_idx == cell_idx) begin
            valid_next = 1'b0;
            count_next = '0;
        end else if (cmd.hit_inc && cmd.hit_idx == cell_idx && count_reg != '1) begin
            count_next = count_reg + lfu_pkg::COUNT_BITS'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            count_reg <= '0;
        end else begin
            valid_reg <= valid_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        page_reg <= page_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg.valid <= 1'b0;
        end else begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule
